FILE: rtl/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

    // Control group that travels alongside the data through every stage.
    typedef struct packed {
        logic valid;
        logic neg;
        logic ovf;
        logic dz;
    } t_ctl;

endpackage
`default_nettype wire

FILE: rtl/sdt_if.sv
`default_nettype none
interface sdt_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sdt_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         overflowed;
    logic                         zero_divisor;

    modport source (output valid, output quotient, output overflowed,
                    output zero_divisor, input ready);
    modport sink   (input valid, input quotient, input overflowed,
                    input zero_divisor, output ready);
endinterface
`default_nettype wire

FILE: rtl/sdt_cell.sv
`default_nettype none
module sdt_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire sdt_pkg::t_ctl         i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_rem,
    input  wire logic [DATA_WIDTH-1:0] i_aq,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    output sdt_pkg::t_ctl              o_ctl,
    output logic      [DATA_WIDTH-1:0] o_rem,
    output logic      [DATA_WIDTH-1:0] o_aq,
    output logic      [DATA_WIDTH-1:0] o_den
);

    sdt_pkg::t_ctl         r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_aq;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_aq;
    logic [DATA_WIDTH:0]   w_shifted;
    logic [DATA_WIDTH:0]   w_trial;
    logic                  w_fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    // The dividend shifts out at the top while quotient bits fill in at the bottom.
    always_comb begin
        w_shifted = {i_rem, i_aq[DATA_WIDTH-1]};
        w_trial   = w_shifted - {1'b0, i_den};
        w_fits    = ~w_trial[DATA_WIDTH];
        n_rem     = w_fits ? w_trial[DATA_WIDTH-1:0] : w_shifted[DATA_WIDTH-1:0];
        n_aq      = {i_aq[DATA_WIDTH-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_aq  <= n_aq;
            r_den <= i_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_aq  = r_aq;
    assign o_den = r_den;

endmodule
`default_nettype wire

FILE: rtl/signed_divide_trunc_sat.sv
// Signed integer divider, quotient truncated toward zero.
// Input channel i_in carries a word of dividend and divisor; output channel
// o_out carries a word of quotient, overflowed and zero_divisor. A word moves
// on a rising edge with valid and ready both high.
// A sign/magnitude stage, a row of DATA_WIDTH restoring-division cells (one
// quotient bit per cell) and a sign fix-up/output register make the path.
// The row moves in lock step; it takes one word per cycle as long as results
// are taken, and several words may be in flight at once.
// The most negative value divided by minus one saturates to the largest
// positive value with overflowed set. A zero divisor gives zero with
// zero_divisor set.
// When the receiver stalls while a result waits, the whole row holds and
// i_in.ready drops; nothing is lost or repeated. A result already in the
// output register does not block taking a new word when it is taken the same
// cycle.
// Synchronous reset empties every stage and the output register.
`default_nettype none
module signed_divide_trunc_sat #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdt_in_if.sink      i_in,
    sdt_out_if.source   o_out
);

    localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MaxVal = ~MinVal;

    logic                  w_adv;
    logic [DATA_WIDTH-1:0] w_a;
    logic [DATA_WIDTH-1:0] w_b;
    sdt_pkg::t_ctl         n_ctl0;

    sdt_pkg::t_ctl         r_ctl0;
    logic [DATA_WIDTH-1:0] r_ma;
    logic [DATA_WIDTH-1:0] r_mb;

    sdt_pkg::t_ctl         w_ctl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_aq  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] w_den [0:DATA_WIDTH];

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_quot;
    logic                  r_ovf;
    logic                  r_dz;
    logic [DATA_WIDTH-1:0] n_quot;

    assign w_adv      = ~r_out_valid | o_out.ready;
    assign i_in.ready = w_adv;

    always_comb begin
        w_a          = i_in.dividend;
        w_b          = i_in.divisor;
        n_ctl0.valid = i_in.valid;
        n_ctl0.neg   = w_a[DATA_WIDTH-1] ^ w_b[DATA_WIDTH-1];
        n_ctl0.dz    = (w_b == '0);
        n_ctl0.ovf   = (w_b != '0) && (w_a == MinVal) && (w_b == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (w_adv) begin
            r_ctl0 <= n_ctl0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ma <= w_a[DATA_WIDTH-1] ? (~w_a + 1'b1) : w_a;
            r_mb <= w_b[DATA_WIDTH-1] ? (~w_b + 1'b1) : w_b;
        end
    end

    assign w_ctl[0] = r_ctl0;
    assign w_rem[0] = '0;
    assign w_aq[0]  = r_ma;
    assign w_den[0] = r_mb;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sdt_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_aq    (w_aq[g]),
            .i_den   (w_den[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_aq    (w_aq[g+1]),
            .o_den   (w_den[g+1])
        );
    end

    // The last cell's remainder is not part of the result.
    always_comb begin
        if (w_ctl[DATA_WIDTH].dz) begin
            n_quot = '0;
        end else if (w_ctl[DATA_WIDTH].ovf) begin
            n_quot = MaxVal;
        end else if (w_ctl[DATA_WIDTH].neg) begin
            n_quot = ~w_aq[DATA_WIDTH] + 1'b1;
        end else begin
            n_quot = w_aq[DATA_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_ctl[DATA_WIDTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctl[DATA_WIDTH].valid) begin
            r_quot <= n_quot;
            r_ovf  <= w_ctl[DATA_WIDTH].ovf;
            r_dz   <= w_ctl[DATA_WIDTH].dz;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.quotient     = r_quot;
    assign o_out.overflowed   = r_ovf;
    assign o_out.zero_divisor = r_dz;

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_ovf && r_dz))
        else $error("overflow and zero divisor flagged together");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dz) |-> (r_quot == '0))
        else $error("zero divisor result is not zero");

    a_ovf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ovf) |-> (r_quot == MaxVal))
        else $error("overflow result is not saturated");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !r_out_valid)
        else $error("result valid right after reset");

    a_last_cell_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !w_ctl[DATA_WIDTH].valid)
        else $error("cell row not emptied by reset");

endmodule
`default_nettype wire

FILE: bench/signed_divide_trunc_sat_tb.sv
`timescale 1ns / 100ps

module signed_divide_trunc_sat_tb;

    localparam int W = 32;
    localparam int LATENCY = W + 2;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MAX_VAL = ~MIN_VAL;

    typedef struct packed {
        logic signed [W-1:0] dividend;
        logic signed [W-1:0] divisor;
        logic signed [W-1:0] quotient;
        logic                overflowed;
        logic                zero_divisor;
    } quot_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sdt_in_if  #(.DATA_WIDTH(W)) in_if ();
    sdt_out_if #(.DATA_WIDTH(W)) out_if ();

    signed_divide_trunc_sat #(.DATA_WIDTH(W)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    quot_result_t pending_quotients[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           holdoff_serial = 0;
    int           holdoff_seen = 0;
    int           holdoff_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_divide_trunc_sat_tb: errors");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holdoff_serial != holdoff_seen) begin
                holdoff_seen = holdoff_serial;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic quot_result_t predict_quotient(input logic signed [W-1:0] a,
                                                      input logic signed [W-1:0] b);
        quot_result_t r;
        logic [W-1:0] mag_a;
        logic [W-1:0] mag_b;
        logic [W-1:0] mag_q;
        r = '0;
        r.dividend = a;
        r.divisor = b;
        if (b == 0) begin
            r.zero_divisor = 1'b1;
        end else if (a == MIN_VAL && b == -1) begin
            r.quotient = MAX_VAL;
            r.overflowed = 1'b1;
        end else if (a != 0) begin
            // Negating the minimum wraps to itself, which is the right unsigned magnitude.
            mag_a = a[W-1] ? -a : a;
            mag_b = b[W-1] ? -b : b;
            mag_q = mag_a / mag_b;
            r.quotient = (a[W-1] ^ b[W-1]) ? -mag_q : mag_q;
        end
        return r;
    endfunction

    always @(posedge clk) begin
        quot_result_t exp_r;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_quotients.size() == 0) begin
                $display("%0t: unexpected word: quotient %0d overflowed %0b zero_divisor %0b",
                         $time, out_if.quotient, out_if.overflowed, out_if.zero_divisor);
                mismatch_count++;
            end else begin
                exp_r = pending_quotients.pop_front();
                if (out_if.quotient !== exp_r.quotient) begin
                    $display("%0t: %0d / %0d quotient: expected %0d, actual %0d", $time,
                             exp_r.dividend, exp_r.divisor, exp_r.quotient, out_if.quotient);
                    mismatch_count++;
                end
                if (out_if.overflowed !== exp_r.overflowed) begin
                    $display("%0t: %0d / %0d overflowed: expected %0b, actual %0b", $time,
                             exp_r.dividend, exp_r.divisor, exp_r.overflowed,
                             out_if.overflowed);
                    mismatch_count++;
                end
                if (out_if.zero_divisor !== exp_r.zero_divisor) begin
                    $display("%0t: %0d / %0d zero_divisor: expected %0b, actual %0b", $time,
                             exp_r.dividend, exp_r.divisor, exp_r.zero_divisor,
                             out_if.zero_divisor);
                    mismatch_count++;
                end
            end
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.dividend <= a;
        in_if.divisor  <= b;
        do @(posedge clk); while (!in_if.ready);
        pending_quotients.push_back(predict_quotient(a, b));
    endtask

    function automatic logic signed [W-1:0] pick_operand();
        logic signed [W-1:0] op;
        int                  s;
        case ($urandom_range(9))
            0, 1, 2: op = W'({$urandom(), $urandom()});
            3, 4: op = W'({$urandom(), $urandom()}) >>> $urandom_range(W - 1);
            5, 6: begin
                s = int'($urandom_range(40)) - 20;
                op = s;
            end
            7: begin
                op = 1;
                op = op << $urandom_range(W - 1);
                if ($urandom_range(1)) op = -op;
            end
            default: begin
                case ($urandom_range(4))
                    0: op = MIN_VAL;
                    1: op = MAX_VAL;
                    2: op = -1;
                    3: op = 1;
                    default: op = 0;
                endcase
            end
        endcase
        return op;
    endfunction

    task automatic send_random_words(input int count);
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        int                  k;
        repeat (count) begin
            b = pick_operand();
            if ($urandom_range(7) == 0) begin
                // Exact multiples, sometimes off by one, to probe the truncation edge.
                k = int'($urandom_range(200)) - 100;
                a = b * k + (int'($urandom_range(2)) - 1);
            end else begin
                a = pick_operand();
            end
            send_word(a, b);
        end
    endtask

    task automatic test_sign_and_saturation();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(MIN_VAL, -1);
        send_word(MIN_VAL, 1);
        send_word(MAX_VAL, -1);
        send_word(MAX_VAL, 1);
        send_word(MIN_VAL, MIN_VAL);
        send_word(MAX_VAL, MAX_VAL);
        send_word(MIN_VAL, MAX_VAL);
        send_word(MAX_VAL, MIN_VAL);
        send_word(0, 0);
        send_word(MIN_VAL, 0);
        send_word(MAX_VAL, 0);
        send_word(-5, 0);
        send_word(0, 5);
        send_word(0, -1);
        send_word(0, MIN_VAL);
        send_word(7, 2);
        send_word(-7, 2);
        send_word(7, -2);
        send_word(-7, -2);
        send_word(1, MAX_VAL);
        send_word(-1, MIN_VAL);
        send_word(-1, -1);
        send_word(MIN_VAL, 2);
        send_word(MIN_VAL, -2);
        send_word(MAX_VAL, 3);
    endtask

    task automatic test_random_steady();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_words(150);
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct = 61;
        recv_stall_pct = 0;
        send_random_words(150);
    endtask

    task automatic test_random_receiver_stalls();
        send_idle_pct = 0;
        recv_stall_pct = 61;
        send_random_words(150);
    endtask

    task automatic test_random_light_gaps();
        send_idle_pct = 6;
        recv_stall_pct = 6;
        send_random_words(140);
    endtask

    // The receiver holds off long enough for the row to fill and push back on the input.
    task automatic test_input_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_serial++;
        send_random_words(60);
    endtask

    initial begin
        rst_n          <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.dividend <= '0;
        in_if.divisor  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sign_and_saturation();
        test_random_steady();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_light_gaps();
        test_input_backpressure();

        in_if.valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_quotients.size() != 0) @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (mismatch_count == 0 && pending_quotients.size() == 0) begin
            $display("signed_divide_trunc_sat_tb: clean");
        end else begin
            $display("signed_divide_trunc_sat_tb: errors");
        end
        $finish;
    end

endmodule
